// ===== rtl/core/ymodem_crc_receiver_top_assert.svh =====
// assertion macros for the ymodem crc receiver
// used by ymodem_crc_receiver_top, expects clk and rst in scope
`ifndef YMODEM_CRC_RECEIVER_TOP_ASSERT_SVH
`define YMODEM_CRC_RECEIVER_TOP_ASSERT_SVH

// same-cycle implication
`define YMCR_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// next-cycle implication
`define YMCR_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/ymcr_pkg.sv =====
// shared types and constants for the ymodem crc receiver
// no dependencies
`default_nettype none
package ymcr_pkg;

  localparam int LONG_DATA_DEF  = 1024;
  localparam int SHORT_DATA_DEF = 128;
  localparam int RES_DEPTH      = 4;

  localparam logic [7:0] B_SOH = 8'h01;
  localparam logic [7:0] B_STX = 8'h02;
  localparam logic [7:0] B_EOT = 8'h04;
  localparam logic [7:0] B_ACK = 8'h06;
  localparam logic [7:0] B_NAK = 8'h15;
  localparam logic [7:0] B_CAN = 8'h18;
  localparam logic [7:0] B_REQ = 8'h43;

  localparam logic [15:0] CRC_POLY = 16'h1021;

  localparam logic [1:0] FUNC_BYTE  = 2'd0;
  localparam logic [1:0] FUNC_TICK  = 2'd1;
  localparam logic [1:0] FUNC_START = 2'd2;
  localparam logic [1:0] FUNC_RSVD  = 2'd3;

  localparam logic [2:0] KIND_SEND    = 3'd0;
  localparam logic [2:0] KIND_STAGE   = 3'd1;
  localparam logic [2:0] KIND_COMMIT  = 3'd2;
  localparam logic [2:0] KIND_DISCARD = 3'd3;
  localparam logic [2:0] KIND_FINISH  = 3'd4;

  localparam logic [2:0] REG_FLASH_BASE = 3'd0;
  localparam logic [2:0] REG_HANDSHAKE  = 3'd1;
  localparam logic [2:0] REG_HEADER     = 3'd2;
  localparam logic [2:0] REG_BODY       = 3'd3;
  localparam logic [2:0] REG_END        = 3'd4;

  localparam logic [15:0] HANDSHAKE_TICKS_RST = 16'd1000;
  localparam logic [15:0] HEADER_TICKS_RST    = 16'd5000;
  localparam logic [15:0] BODY_TICKS_RST      = 16'd5000;
  localparam logic [15:0] END_TICKS_RST       = 16'd3000;

  typedef struct packed {
    logic [2:0]  kind;
    logic [7:0]  tx_byte;
    logic [9:0]  data_offset;
    logic [7:0]  data_byte;
    logic [31:0] flash_addr;
    logic [10:0] write_len;
    logic [31:0] total_written;
    logic        last;
  } ymcr_result_t;

  function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

endpackage
`default_nettype wire

// ===== rtl/core/ymcr_out_queue.sv =====
// result queue: takes up to three results per cycle, hands out one per transfer
// depends on ymcr_pkg
`default_nettype none
module ymcr_out_queue
  import ymcr_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic [1:0]   push_count,
  input  ymcr_result_t      push_data [3],
  output logic              room,
  output logic              out_valid,
  input  wire logic         out_ready,
  output ymcr_result_t      out_data
);

  localparam int PW = $clog2(RES_DEPTH);

  ymcr_result_t    entries [RES_DEPTH];
  logic [PW-1:0]   wr_ptr;
  logic [PW-1:0]   rd_ptr;
  logic [PW:0]     count;
  logic            pop;

  assign out_valid = (count != '0);
  assign out_data  = entries[rd_ptr];
  assign pop       = out_valid && out_ready;
  assign room      = (count <= (PW+1)'(RES_DEPTH - 3));

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PW'(push_count);
      if (pop) rd_ptr <= rd_ptr + PW'(1);
      count <= count + (PW+1)'(push_count) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < 3; i++) begin
      if (2'(i) < push_count) entries[wr_ptr + PW'(i)] <= push_data[i];
    end
  end

endmodule
`default_nettype wire

// ===== rtl/core/ymodem_crc_receiver_top.sv =====
// results of an input transfer are registered in the output queue before they reach the master side
// throughput: one input per cycle while each input yields at most one result and
//   the sink is ready; each extra result of an input can hold off the next input
// reset: synchronous rst returns to idle with registers at their reset values
// ymodem crc receiver top level, depends on ymcr_pkg and ymcr_out_queue
`default_nettype none
`include "ymodem_crc_receiver_top_assert.svh"
module ymodem_crc_receiver_top
  import ymcr_pkg::*;
#(
  parameter int LONG_DATA  = LONG_DATA_DEF,
  parameter int SHORT_DATA = SHORT_DATA_DEF
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  input  wire logic [7:0]   s_tdata,   // rx_byte
  input  wire logic [1:0]   s_tuser,   // func
  output logic              m_tvalid,
  input  wire logic         m_tready,
  output logic [103:0]      m_tdata,   // tx_byte, data_offset, data_byte, flash_addr,
                                       // write_len, total_written, zero pad
  output logic [2:0]        m_tuser,   // kind
  output logic              m_tlast,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_addr,
  input  wire logic [31:0]  cfg_wdata
);

  localparam logic [11:0] LONG_LEN  = 12'(LONG_DATA);
  localparam logic [11:0] SHORT_LEN = 12'(SHORT_DATA);
  localparam logic [10:0] FINAL_END = 11'(SHORT_DATA + 4);

  typedef enum logic [3:0] {
    PH_IDLE, PH_HANDSHAKE, PH_HEADER, PH_BODY, PH_EOT2, PH_FINAL, PH_FINAL_BODY
  } phase_t;

  typedef enum logic [1:0] {SCAN_NAME, SCAN_DIGITS, SCAN_DONE} scan_t;

  logic [31:0] flash_base;
  logic [15:0] handshake_ticks, header_ticks, body_ticks, end_ticks;

  phase_t      phase, phase_next;
  logic [15:0] tick_count, tick_count_next;
  logic [10:0] byte_index, byte_index_next;
  logic        long_packet, long_packet_next;
  logic [7:0]  seq_byte, seq_byte_next;
  logic [15:0] crc_running, crc_running_next;
  logic [15:0] crc_received, crc_received_next;
  logic        awaiting_name, awaiting_name_next;
  logic [31:0] file_length, file_length_next;
  logic [31:0] length_tentative, length_tentative_next;
  scan_t       name_scan, name_scan_next;
  logic [31:0] bytes_done, bytes_done_next;

  logic         accept;
  logic         room;
  logic [1:0]   nres;
  ymcr_result_t res [3];
  ymcr_result_t head;

  logic [11:0] dlen;
  logic [15:0] tick_inc;
  logic [15:0] crc_full;
  logic [32:0] end_sum;
  logic [10:0] wlen;
  logic [31:0] done_sum;
  logic        crc_ok;

  assign s_tready = room;
  assign accept   = s_tvalid && s_tready;

  function automatic ymcr_result_t mk(input logic [2:0] k, input logic [7:0] tx,
                                      input logic [31:0] tot);
    ymcr_result_t r;
    r = '0;
    r.kind = k;
    r.tx_byte = tx;
    r.total_written = tot;
    return r;
  endfunction

  always_comb begin
    dlen     = long_packet ? LONG_LEN : SHORT_LEN;
    tick_inc = (tick_count != 16'hFFFF) ? tick_count + 16'd1 : tick_count;
    crc_full = {crc_received[15:8], s_tdata};
    crc_ok   = (seq_byte == 8'hFF) && (crc_full == crc_running);
    end_sum  = {1'b0, bytes_done} + {21'd0, dlen[10:0]};
    wlen     = dlen[10:0];
    if (file_length != '0 && end_sum > {1'b0, file_length}) begin
      wlen = (file_length >= bytes_done) ? 11'(file_length - bytes_done) : 11'd0;
    end
    done_sum = bytes_done + {21'd0, wlen};
  end

  always_comb begin
    phase_next            = phase;
    tick_count_next       = tick_count;
    byte_index_next       = byte_index;
    long_packet_next      = long_packet;
    seq_byte_next         = seq_byte;
    crc_running_next      = crc_running;
    crc_received_next     = crc_received;
    awaiting_name_next    = awaiting_name;
    file_length_next      = file_length;
    length_tentative_next = length_tentative;
    name_scan_next        = name_scan;
    bytes_done_next       = bytes_done;
    nres = 2'd0;
    for (int i = 0; i < 3; i++) res[i] = '0;

    unique case (s_tuser)
      FUNC_START: begin
        phase_next = PH_HANDSHAKE;
        tick_count_next = '0;
        byte_index_next = '0;
        awaiting_name_next = 1'b1;
        file_length_next = '0;
        length_tentative_next = '0;
        name_scan_next = SCAN_NAME;
        bytes_done_next = '0;
        res[0] = mk(KIND_SEND, B_REQ, '0);
        nres = 2'd1;
      end
      FUNC_BYTE: begin
        unique case (phase)
          PH_HANDSHAKE, PH_HEADER: begin
            if (phase == PH_HEADER) tick_count_next = '0;
            if (s_tdata == B_SOH || s_tdata == B_STX) begin
              phase_next = PH_BODY;
              long_packet_next = (s_tdata == B_STX);
              byte_index_next = '0;
              seq_byte_next = '0;
              crc_running_next = '0;
              crc_received_next = '0;
              length_tentative_next = '0;
              name_scan_next = SCAN_NAME;
              tick_count_next = '0;
            end else if (phase == PH_HANDSHAKE) begin
              res[0] = mk(KIND_SEND, B_REQ, '0);
              nres = 2'd1;
              tick_count_next = '0;
            end else if (s_tdata == B_EOT) begin
              res[0] = mk(KIND_SEND, B_NAK, '0);
              nres = 2'd1;
              phase_next = PH_EOT2;
            end else if (s_tdata == B_CAN) begin
              res[0] = mk(KIND_FINISH, '0, bytes_done);
              nres = 2'd1;
              phase_next = PH_IDLE;
              tick_count_next = '0;
            end
          end
          PH_BODY: begin
            byte_index_next = byte_index + 11'd1;
            if (byte_index == 11'd0) begin
              seq_byte_next = s_tdata;
            end else if (byte_index == 11'd1) begin
              seq_byte_next = seq_byte ^ s_tdata;
            end else if ({1'b0, byte_index} < dlen + 12'd2) begin
              crc_running_next = crc_update(crc_running, s_tdata);
              if (awaiting_name) begin
                if (name_scan == SCAN_NAME) begin
                  if (s_tdata == 8'h00) name_scan_next = SCAN_DIGITS;
                end else if (name_scan == SCAN_DIGITS) begin
                  if (s_tdata >= 8'h30 && s_tdata <= 8'h39) begin
                    length_tentative_next = {length_tentative[28:0], 3'b000}
                      + {length_tentative[30:0], 1'b0} + {24'd0, s_tdata - 8'h30};
                  end else begin
                    name_scan_next = SCAN_DONE;
                  end
                end
              end else begin
                res[0] = '0;
                res[0].kind = KIND_STAGE;
                res[0].data_offset = 10'(byte_index - 11'd2);
                res[0].data_byte = s_tdata;
                nres = 2'd1;
              end
            end else if ({1'b0, byte_index} == dlen + 12'd2) begin
              crc_received_next = {s_tdata, 8'h00};
            end else begin
              crc_received_next = crc_full;
              phase_next = PH_HEADER;
              tick_count_next = '0;
              if (!crc_ok) begin
                if (awaiting_name) begin
                  res[0] = mk(KIND_SEND, B_NAK, '0);
                  nres = 2'd1;
                end else begin
                  res[0] = mk(KIND_DISCARD, '0, '0);
                  res[1] = mk(KIND_SEND, B_NAK, '0);
                  nres = 2'd2;
                end
              end else if (awaiting_name) begin
                awaiting_name_next = 1'b0;
                file_length_next = (name_scan == SCAN_NAME) ? '0 : length_tentative;
                res[0] = mk(KIND_SEND, B_ACK, '0);
                res[1] = mk(KIND_SEND, B_REQ, '0);
                nres = 2'd2;
              end else begin
                bytes_done_next = done_sum;
                res[0] = mk(KIND_COMMIT, '0, done_sum);
                res[0].flash_addr = flash_base + bytes_done;
                res[0].write_len = wlen;
                res[1] = mk(KIND_SEND, B_ACK, '0);
                nres = 2'd2;
              end
            end
          end
          PH_EOT2: begin
            if (s_tdata == B_EOT) begin
              res[0] = mk(KIND_SEND, B_ACK, '0);
              res[1] = mk(KIND_SEND, B_REQ, '0);
              nres = 2'd2;
              phase_next = PH_FINAL;
              tick_count_next = '0;
            end else begin
              res[0] = mk(KIND_FINISH, '0, bytes_done);
              nres = 2'd1;
              phase_next = PH_IDLE;
              tick_count_next = '0;
            end
          end
          PH_FINAL: begin
            if (s_tdata == B_SOH) begin
              phase_next = PH_FINAL_BODY;
              byte_index_next = '0;
              tick_count_next = '0;
            end else begin
              res[0] = mk(KIND_FINISH, '0, bytes_done);
              nres = 2'd1;
              phase_next = PH_IDLE;
              tick_count_next = '0;
            end
          end
          PH_FINAL_BODY: begin
            byte_index_next = byte_index + 11'd1;
            if (byte_index + 11'd1 >= FINAL_END) begin
              res[0] = mk(KIND_SEND, B_ACK, '0);
              res[1] = mk(KIND_FINISH, '0, bytes_done);
              nres = 2'd2;
              phase_next = PH_IDLE;
              tick_count_next = '0;
            end
          end
          default: ;
        endcase
      end
      FUNC_TICK: begin
        if (phase != PH_IDLE) begin
          tick_count_next = tick_inc;
          unique case (phase)
            PH_HANDSHAKE: begin
              if (tick_inc >= handshake_ticks) begin
                res[0] = mk(KIND_SEND, B_REQ, '0);
                nres = 2'd1;
                tick_count_next = '0;
              end
            end
            PH_HEADER: begin
              if (tick_inc >= header_ticks) begin
                res[0] = mk(KIND_SEND, B_CAN, '0);
                res[1] = mk(KIND_SEND, B_CAN, '0);
                res[2] = mk(KIND_FINISH, '0, bytes_done);
                nres = 2'd3;
                phase_next = PH_IDLE;
                tick_count_next = '0;
              end
            end
            PH_BODY: begin
              if (tick_inc >= body_ticks) begin
                phase_next = PH_HEADER;
                tick_count_next = '0;
                if (awaiting_name) begin
                  res[0] = mk(KIND_SEND, B_NAK, '0);
                  nres = 2'd1;
                end else begin
                  res[0] = mk(KIND_DISCARD, '0, '0);
                  res[1] = mk(KIND_SEND, B_NAK, '0);
                  nres = 2'd2;
                end
              end
            end
            default: begin
              if (tick_inc >= end_ticks) begin
                res[0] = mk(KIND_FINISH, '0, bytes_done);
                nres = 2'd1;
                phase_next = PH_IDLE;
                tick_count_next = '0;
              end
            end
          endcase
        end
      end
      default: ;
    endcase

    if (nres != 2'd0) res[nres - 2'd1].last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flash_base      <= '0;
      handshake_ticks <= HANDSHAKE_TICKS_RST;
      header_ticks    <= HEADER_TICKS_RST;
      body_ticks      <= BODY_TICKS_RST;
      end_ticks       <= END_TICKS_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_FLASH_BASE: flash_base      <= cfg_wdata;
        REG_HANDSHAKE:  handshake_ticks <= cfg_wdata[15:0];
        REG_HEADER:     header_ticks    <= cfg_wdata[15:0];
        REG_BODY:       body_ticks      <= cfg_wdata[15:0];
        REG_END:        end_ticks       <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase            <= PH_IDLE;
      tick_count       <= '0;
      byte_index       <= '0;
      long_packet      <= 1'b0;
      seq_byte         <= '0;
      crc_running      <= '0;
      crc_received     <= '0;
      awaiting_name    <= 1'b1;
      file_length      <= '0;
      length_tentative <= '0;
      name_scan        <= SCAN_NAME;
      bytes_done       <= '0;
    end else if (accept) begin
      phase            <= phase_next;
      tick_count       <= tick_count_next;
      byte_index       <= byte_index_next;
      long_packet      <= long_packet_next;
      seq_byte         <= seq_byte_next;
      crc_running      <= crc_running_next;
      crc_received     <= crc_received_next;
      awaiting_name    <= awaiting_name_next;
      file_length      <= file_length_next;
      length_tentative <= length_tentative_next;
      name_scan        <= name_scan_next;
      bytes_done       <= bytes_done_next;
    end
  end

  ymcr_out_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_count (accept ? nres : 2'd0),
    .push_data  (res),
    .room       (room),
    .out_valid  (m_tvalid),
    .out_ready  (m_tready),
    .out_data   (head)
  );

  assign m_tuser = head.kind;
  assign m_tlast = head.last;
  assign m_tdata = {3'b000, head.total_written, head.write_len, head.flash_addr,
                    head.data_byte, head.data_offset, head.tx_byte};

  `YMCR_ASSERT_NEXT(a_result_shows, accept && nres != 2'd0, m_tvalid)
  `YMCR_ASSERT_NOW(a_idle_timer_clear, phase == PH_IDLE, tick_count == 16'd0)
  `YMCR_ASSERT_NOW(a_no_stage_on_name, accept && awaiting_name, res[0].kind != KIND_STAGE)

endmodule
`default_nettype wire

// ===== tb/sv/ymodem_crc_receiver_top_test.sv =====
// testbench for ymodem_crc_receiver_top: streams bytes, ticks and starts into the block
// and checks every result against a scoreboard class with its own receiver model
// depends on ymcr_pkg and the rtl of ymodem_crc_receiver_top
`timescale 1ns / 100ps
module ymodem_crc_receiver_top_test
  import ymcr_pkg::*;
();

  localparam int CYCLE_LIMIT = 3000000;

  typedef enum logic [3:0] {
    ST_IDLE, ST_HANDSHAKE, ST_HEADER, ST_BODY, ST_EOT2, ST_FINAL, ST_FINAL_BODY
  } rx_phase_t;

  class rx_scoreboard_t;
    logic [31:0] flash_base;
    logic [15:0] hs_ticks, hd_ticks, bd_ticks, end_ticks;
    rx_phase_t   phase;
    logic [15:0] tick_cnt;
    logic [10:0] idx;
    logic        long_pkt;
    logic [7:0]  seq_x;
    logic [15:0] crc_run, crc_rcv;
    logic        want_name;
    logic [31:0] file_len, len_acc;
    logic [1:0]  scan;
    logic [31:0] done;
    ymcr_result_t cur[$];
    ymcr_result_t results_due[$];
    int errors;

    function new();
      flash_base = 0;
      hs_ticks = HANDSHAKE_TICKS_RST;
      hd_ticks = HEADER_TICKS_RST;
      bd_ticks = BODY_TICKS_RST;
      end_ticks = END_TICKS_RST;
      phase = ST_IDLE;
      tick_cnt = 0; idx = 0; long_pkt = 0; seq_x = 0; crc_run = 0; crc_rcv = 0;
      want_name = 1; file_len = 0; len_acc = 0; scan = 0; done = 0;
      errors = 0;
    endfunction

    static function logic [15:0] crc_next(logic [15:0] c, logic [7:0] d);
      logic fb;
      for (int i = 7; i >= 0; i--) begin
        fb = c[15] ^ d[i];
        c = {c[14:0], 1'b0};
        if (fb) c = c ^ 16'h1021;
      end
      return c;
    endfunction

    function void write_reg(logic [2:0] ra, logic [31:0] v);
      case (ra)
        REG_FLASH_BASE: flash_base = v;
        REG_HANDSHAKE:  hs_ticks = v[15:0];
        REG_HEADER:     hd_ticks = v[15:0];
        REG_BODY:       bd_ticks = v[15:0];
        REG_END:        end_ticks = v[15:0];
        default: ;
      endcase
    endfunction

    function void put(logic [2:0] k, logic [7:0] tx, logic [9:0] off, logic [7:0] db,
                      logic [31:0] addr, logic [10:0] len, logic [31:0] tot);
      ymcr_result_t r;
      if (cur.size() >= 3) return;
      r.kind = k; r.tx_byte = tx; r.data_offset = off; r.data_byte = db;
      r.flash_addr = addr; r.write_len = len; r.total_written = tot; r.last = 0;
      cur.push_back(r);
    endfunction

    function void tx(logic [7:0] b);
      put(KIND_SEND, b, 0, 0, 0, 0, 0);
    endfunction

    function void finished();
      put(KIND_FINISH, 0, 0, 0, 0, 0, done);
      phase = ST_IDLE;
      tick_cnt = 0;
    endfunction

    function void open_packet(logic is_long);
      phase = ST_BODY; long_pkt = is_long; idx = 0; seq_x = 0; crc_run = 0;
      crc_rcv = 0; len_acc = 0; scan = 0; tick_cnt = 0;
    endfunction

    function void reject();
      if (!want_name) put(KIND_DISCARD, 0, 0, 0, 0, 0, 0);
      tx(B_NAK);
      phase = ST_HEADER;
      tick_cnt = 0;
    endfunction

    function void close_packet(logic [31:0] dlen);
      logic [31:0] wlen;
      logic [32:0] sum;
      if (seq_x != 8'hFF || crc_rcv != crc_run) begin
        reject();
        return;
      end
      phase = ST_HEADER;
      tick_cnt = 0;
      if (want_name) begin
        want_name = 0;
        file_len = (scan == 0) ? 32'd0 : len_acc;
        tx(B_ACK);
        tx(B_REQ);
        return;
      end
      wlen = dlen;
      sum = {1'b0, done} + dlen;
      if (file_len != 0 && sum > {1'b0, file_len})
        wlen = (file_len >= done) ? file_len - done : 32'd0;
      put(KIND_COMMIT, 0, 0, 0, flash_base + done, wlen[10:0], done + wlen);
      done = done + wlen;
      tx(B_ACK);
    endfunction

    function void body_in(logic [7:0] b);
      logic [31:0] dlen;
      logic [31:0] i;
      dlen = long_pkt ? LONG_DATA_DEF : SHORT_DATA_DEF;
      i = idx;
      idx = idx + 11'd1;
      if (i == 0) seq_x = b;
      else if (i == 1) seq_x = seq_x ^ b;
      else if (i < dlen + 2) begin
        crc_run = crc_next(crc_run, b);
        if (want_name) begin
          if (scan == 0) begin
            if (b == 0) scan = 1;
          end else if (scan == 1) begin
            if (b >= 8'h30 && b <= 8'h39) len_acc = len_acc * 10 + (b - 8'h30);
            else scan = 2;
          end
        end else put(KIND_STAGE, 0, i - 2, b, 0, 0, 0);
      end else if (i == dlen + 2) crc_rcv = {b, 8'h00};
      else begin
        crc_rcv[7:0] = b;
        close_packet(dlen);
      end
    endfunction

    function void byte_in(logic [7:0] b);
      case (phase)
        ST_HANDSHAKE:
          if (b == B_SOH || b == B_STX) open_packet(b == B_STX);
          else begin
            tx(B_REQ);
            tick_cnt = 0;
          end
        ST_HEADER: begin
          tick_cnt = 0;
          if (b == B_SOH || b == B_STX) open_packet(b == B_STX);
          else if (b == B_EOT) begin
            tx(B_NAK);
            phase = ST_EOT2;
          end else if (b == B_CAN) finished();
        end
        ST_BODY: body_in(b);
        ST_EOT2:
          if (b == B_EOT) begin
            tx(B_ACK);
            tx(B_REQ);
            phase = ST_FINAL;
            tick_cnt = 0;
          end else finished();
        ST_FINAL:
          if (b == B_SOH) begin
            phase = ST_FINAL_BODY;
            idx = 0;
            tick_cnt = 0;
          end else finished();
        ST_FINAL_BODY: begin
          idx = idx + 11'd1;
          if (idx >= SHORT_DATA_DEF + 4) begin
            tx(B_ACK);
            finished();
          end
        end
        default: ;
      endcase
    endfunction

    function void tick_in();
      if (phase == ST_IDLE) return;
      if (tick_cnt != 16'hFFFF) tick_cnt++;
      case (phase)
        ST_HANDSHAKE:
          if (tick_cnt >= hs_ticks) begin
            tx(B_REQ);
            tick_cnt = 0;
          end
        ST_HEADER:
          if (tick_cnt >= hd_ticks) begin
            tx(B_CAN);
            tx(B_CAN);
            finished();
          end
        ST_BODY:
          if (tick_cnt >= bd_ticks) reject();
        default:
          if (tick_cnt >= end_ticks) finished();
      endcase
    endfunction

    function void note_input(logic [1:0] f, logic [7:0] b);
      cur.delete();
      if (f == FUNC_BYTE) byte_in(b);
      else if (f == FUNC_TICK) tick_in();
      else if (f == FUNC_START) begin
        phase = ST_HANDSHAKE; tick_cnt = 0; idx = 0; want_name = 1; file_len = 0;
        len_acc = 0; scan = 0; done = 0;
        tx(B_REQ);
      end
      if (cur.size() > 0) cur[cur.size() - 1].last = 1;
      foreach (cur[i]) results_due.push_back(cur[i]);
    endfunction

    function void check_result(ymcr_result_t got);
      ymcr_result_t e;
      if (results_due.size() == 0) begin
        if (errors < 10) $display("unexpected result %p", got);
        errors++;
        return;
      end
      e = results_due.pop_front();
      if (e.kind != got.kind || e.tx_byte != got.tx_byte || e.data_offset != got.data_offset
          || e.data_byte != got.data_byte || e.flash_addr != got.flash_addr
          || e.write_len != got.write_len || e.total_written != got.total_written
          || e.last != got.last) begin
        if (errors < 10) $display("mismatch expected %p actual %p", e, got);
        errors++;
      end
    endfunction
  endclass

  logic         clk, rst;
  logic         s_tvalid, s_tready;
  logic [7:0]   s_tdata;
  logic [1:0]   s_tuser;
  logic         m_tvalid, m_tready;
  logic [103:0] m_tdata;
  logic [2:0]   m_tuser;
  logic         m_tlast;
  logic         cfg_we;
  logic [2:0]   cfg_addr;
  logic [31:0]  cfg_wdata;

  rx_scoreboard_t sb = new();
  int    cycles = 0;
  int    items_sent = 0;
  int    rx_wait = 0;
  int    long_hold = 0;
  bit    quiet = 0;
  bit    held_once = 0;

  ymodem_crc_receiver_top uut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast),
    .cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
  );

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("ymodem_crc_receiver_top_test: errors");
      $finish;
    end
  end

  // transfer monitors
  always @(posedge clk) begin
    ymcr_result_t got;
    if (!rst) begin
      if (s_tvalid && s_tready) sb.note_input(s_tuser, s_tdata);
      if (m_tvalid && m_tready) begin
        got.kind = m_tuser;
        got.tx_byte = m_tdata[7:0];
        got.data_offset = m_tdata[17:8];
        got.data_byte = m_tdata[25:18];
        got.flash_addr = m_tdata[57:26];
        got.write_len = m_tdata[68:58];
        got.total_written = m_tdata[100:69];
        got.last = m_tlast;
        sb.check_result(got);
      end
    end
  end

  // result sink with random stalls and one long hold-off
  always @(posedge clk) begin
    if (rst) m_tready <= 0;
    else if (long_hold > 0) begin
      long_hold--;
      m_tready <= 0;
    end else if (rx_wait > 0) begin
      rx_wait--;
      m_tready <= (rx_wait == 0);
    end else if (m_tvalid && m_tready) begin
      rx_wait = quiet ? 0 : $urandom_range(0, 11);
      m_tready <= (rx_wait == 0);
    end else m_tready <= 1;
  end

  task automatic send_item(logic [1:0] f, logic [7:0] b);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      s_tvalid <= 0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1;
    s_tuser <= f;
    s_tdata <= b;
    do @(posedge clk); while (!s_tready);
    items_sent++;
  endtask

  task automatic drive_byte(logic [7:0] b);
    send_item(FUNC_BYTE, b);
  endtask

  task automatic send_ticks(int n);
    repeat (n) send_item(FUNC_TICK, $urandom);
  endtask

  task automatic drain();
    s_tvalid <= 0;
    @(posedge clk);
    while (sb.results_due.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(logic [31:0] base, logic [15:0] hs, logic [15:0] hd,
                            logic [15:0] bd, logic [15:0] en);
    logic [31:0] vals[5];
    vals = '{base, {16'h0, hs}, {16'h0, hd}, {16'h0, bd}, {16'h0, en}};
    for (int i = 0; i < 5; i++) begin
      cfg_we <= 1;
      cfg_addr <= i[2:0];
      cfg_wdata <= vals[i];
      sb.write_reg(i[2:0], vals[i]);
      @(posedge clk);
    end
    cfg_we <= 0;
  endtask

  function automatic logic [7:0] noise_byte();
    logic [7:0] b;
    do b = $urandom; while (b == B_SOH || b == B_STX || b == B_EOT || b == B_CAN);
    return b;
  endfunction

  // flaw: 0 good, 1 bad complement, 2 bad crc, 3 truncated body then timeout
  task automatic send_packet(logic is_long, logic is_name, int flaw);
    logic [7:0]  payload[$];
    logic [7:0]  seq;
    logic [15:0] crc;
    string       digits;
    int          dlen, cut, style;
    dlen = is_long ? LONG_DATA_DEF : SHORT_DATA_DEF;
    seq = $urandom;
    if (is_name) begin
      style = $urandom_range(0, 7);
      payload.push_back(8'h61 + $urandom_range(0, 25));
      if (style == 0) begin
        while (payload.size() < dlen) payload.push_back(8'h61);
      end else begin
        payload.push_back(8'h00);
        if (style == 1) digits = "";
        else if (style == 2) digits = $sformatf("%0d%0d", $urandom, $urandom);
        else if (style == 3) digits = "0";
        else digits = $sformatf("%0d", $urandom_range(1, 600));
        for (int i = 0; i < digits.len(); i++) payload.push_back(digits[i]);
        payload.push_back(($urandom_range(0, 1) != 0) ? 8'h20 : 8'h00);
        while (payload.size() < dlen) payload.push_back($urandom_range(0, 1) ? $urandom : 0);
      end
    end else begin
      for (int i = 0; i < dlen; i++) payload.push_back($urandom);
    end
    crc = 0;
    foreach (payload[i]) crc = rx_scoreboard_t::crc_next(crc, payload[i]);
    drive_byte(is_long ? B_STX : B_SOH);
    drive_byte(seq);
    drive_byte((flaw == 1) ? ~seq ^ (8'h01 << $urandom_range(0, 7)) : ~seq);
    cut = (flaw == 3) ? $urandom_range(0, dlen - 1) : dlen;
    for (int i = 0; i < cut; i++) drive_byte(payload[i]);
    if (flaw == 3) begin
      send_ticks(sb.bd_ticks);
      return;
    end
    if (flaw == 2) crc = crc ^ (16'h1 << $urandom_range(0, 15));
    drive_byte(crc[15:8]);
    drive_byte(crc[7:0]);
  endtask

  task automatic random_config();
    logic [31:0] base;
    int p;
    p = $urandom_range(0, 3);
    case ($urandom_range(0, 2))
      0: base = 0;
      1: base = 32'hFFFFFFFF - $urandom_range(0, 300);
      default: base = $urandom;
    endcase
    case (p)
      0: set_config(base, $urandom_range(1, 6), $urandom_range(1, 6), $urandom_range(1, 6),
                    $urandom_range(1, 6));
      1: set_config(base, 1, 16'hFFFF, 16'hFFFF, 1);
      2: set_config(base, 16'hFFFF, 1, 1, 16'hFFFF);
      default: set_config(base, HANDSHAKE_TICKS_RST, HEADER_TICKS_RST, BODY_TICKS_RST,
                          END_TICKS_RST);
    endcase
  endtask

  task automatic run_session();
    int npk, flaw, mode;
    send_item(FUNC_START, $urandom);
    send_ticks($urandom_range(0, 3));
    if ($urandom_range(0, 2) == 0) drive_byte(noise_byte());
    if ($urandom_range(0, 7) == 0) send_item(FUNC_RSVD, $urandom);
    if ($urandom_range(0, 5) == 0) send_packet(0, 1, $urandom_range(1, sb.bd_ticks <= 20 ? 3 : 2));
    send_packet($urandom_range(0, 15) == 0, 1, 0);
    npk = $urandom_range(held_once ? 0 : 1, 2);
    for (int k = 0; k < npk; k++) begin
      if ($urandom_range(0, 3) == 0) drive_byte(noise_byte());
      if ($urandom_range(0, 3) == 0) drain();
      flaw = ($urandom_range(0, 4) == 0) ? $urandom_range(1, sb.bd_ticks <= 20 ? 3 : 2) : 0;
      if (!held_once) begin
        held_once = 1;
        long_hold = 300;
        flaw = 0;
      end
      send_packet($urandom_range(0, 7) == 0, 0, flaw);
    end
    mode = $urandom_range(0, 9);
    if (mode <= 4) begin
      drive_byte(B_EOT);
      if ($urandom_range(0, 3) == 0) send_ticks(1);
      drive_byte(B_EOT);
      drive_byte(B_SOH);
      repeat (SHORT_DATA_DEF + 4) drive_byte($urandom);
    end else if (mode == 5) drive_byte(B_CAN);
    else if (mode == 6) begin
      drive_byte(B_EOT);
      drive_byte(noise_byte());
    end else if (mode == 7) begin
      drive_byte(B_EOT);
      drive_byte(B_EOT);
      drive_byte(B_STX);
    end else if (mode == 8) begin
      if (sb.hd_ticks <= 20) send_ticks(sb.hd_ticks);
      else drive_byte(B_CAN);
    end else begin
      drive_byte(B_EOT);
      if (sb.end_ticks <= 20) send_ticks(sb.end_ticks);
      else drive_byte(noise_byte());
    end
  endtask

  initial begin
    rst = 1;
    s_tvalid = 0; s_tdata = 0; s_tuser = 0;
    cfg_we = 0; cfg_addr = 0; cfg_wdata = 0;
    repeat (4) @(posedge clk);
    rst <= 0;
    @(posedge clk);

    // directed: idle inputs, handshake repeats, start mid-packet
    set_config(32'h0, 3, 4, 16'hFFFF, 2);
    drive_byte(8'hFF);
    send_ticks(1);
    send_item(FUNC_RSVD, 8'h00);
    send_item(FUNC_START, 8'h00);
    send_ticks(3);
    drive_byte(8'hFF);
    drive_byte(8'h00);
    drive_byte(B_EOT);
    drive_byte(B_SOH);
    drive_byte(8'h00);
    drive_byte(8'hFF);
    drive_byte(8'h80);
    send_item(FUNC_START, 8'hFF);
    drive_byte(B_STX);
    drive_byte(8'h7F);
    send_item(FUNC_START, 8'h55);
    send_item(FUNC_TICK, 8'hAA);
    drain();

    while (items_sent < 300) begin
      drain();
      random_config();
      quiet = ($urandom_range(0, 3) == 0);
      run_session();
    end

    drain();
    repeat (20) @(posedge clk);
    if (sb.errors == 0 && sb.results_due.size() == 0) $display("ymodem_crc_receiver_top_test: clean");
    else $display("ymodem_crc_receiver_top_test: errors");
    $finish;
  end
endmodule
